>>> hdl/srm_pkg.sv
// Shared constants and types for the running median block.
package srm_pkg;

    localparam int CAPACITY_DEF     = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int IN_W             = 32;
    localparam int MEDIAN_W         = 33;
    localparam int COUNT_W          = 11;

    localparam logic OP_PUSH     = 1'b0;
    localparam logic OP_PUSH_POP = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } heap_cmd_t;

endpackage

>>> hdl/srm_heap.sv
// Binary heap in a single-port-read memory with an iterative sift sequencer.
module srm_heap
    import srm_pkg::*;
#(
    parameter int DEPTH  = (CAPACITY_DEF + 1) / 2,
    parameter int DW     = SAMPLE_WIDTH_DEF,
    parameter bit IS_MAX = 1'b1,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int SW    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  heap_cmd_t            cmd,
    input  logic signed [DW-1:0] din,
    output logic                 busy,
    output logic signed [DW-1:0] result,
    output logic signed [DW-1:0] top,
    output logic [SW-1:0]        size
);

    localparam int IW = AW + 2;

    localparam logic [2:0] H_IDLE   = 3'd0;
    localparam logic [2:0] H_UP_CHK = 3'd1;
    localparam logic [2:0] H_UP_CMP = 3'd2;
    localparam logic [2:0] H_DN_L   = 3'd3;
    localparam logic [2:0] H_DN_R   = 3'd4;
    localparam logic [2:0] H_DN_CMP = 3'd5;

    logic signed [DW-1:0] mem [DEPTH];

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic [SW-1:0]        size_reg, size_next;
    logic signed [DW-1:0] lv_reg, lv_next;
    logic                 has_r_reg, has_r_next;
    logic signed [DW-1:0] result_reg, result_next;
    logic signed [DW-1:0] top_reg;
    logic signed [DW-1:0] rdata_reg;

    logic                 we, rd_en;
    logic [AW-1:0]        waddr, raddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        parent;
    logic [IW-1:0]        lidx, ridx, best, size_x;
    logic signed [DW-1:0] cand;

    function automatic logic ranks(input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b);
        ranks = IS_MAX ? (a > b) : (a < b);
    endfunction

    assign parent = AW'((pos_reg - 1'b1) >> 1);
    assign lidx   = {1'b0, pos_reg, 1'b1};
    assign ridx   = lidx + 1'b1;
    assign size_x = IW'(size_reg);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        size_next   = size_reg;
        lv_next     = lv_reg;
        has_r_next  = has_r_reg;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = val_reg;
        rd_en       = 1'b0;
        raddr       = parent;
        cand        = val_reg;
        best        = IW'(pos_reg);
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.op == OP_PUSH)
                    begin
                        if (size_reg != SW'(DEPTH))
                        begin
                            val_next   = din;
                            pos_next   = AW'(size_reg);
                            size_next  = size_reg + 1'b1;
                            state_next = H_UP_CHK;
                        end
                    end
                    else if (size_reg == '0 || !ranks(top_reg, din))
                    begin
                        result_next = din;
                    end
                    else
                    begin
                        result_next = top_reg;
                        val_next    = din;
                        pos_next    = '0;
                        state_next  = H_DN_L;
                    end
                end
            end
            H_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP:
            begin
                we = 1'b1;
                if (ranks(val_reg, rdata_reg))
                begin
                    wdata      = rdata_reg;
                    pos_next   = parent;
                    state_next = H_UP_CHK;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            H_DN_L:
            begin
                if (lidx < size_x)
                begin
                    rd_en      = 1'b1;
                    raddr      = lidx[AW-1:0];
                    state_next = H_DN_R;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end
            end
            H_DN_R:
            begin
                lv_next    = rdata_reg;
                has_r_next = ridx < size_x;
                rd_en      = ridx < size_x;
                raddr      = ridx[AW-1:0];
                state_next = H_DN_CMP;
            end
            H_DN_CMP:
            begin
                if (ranks(lv_reg, cand))
                begin
                    cand = lv_reg;
                    best = lidx;
                end
                if (has_r_reg && ranks(rdata_reg, cand))
                begin
                    cand = rdata_reg;
                    best = ridx;
                end
                we    = 1'b1;
                wdata = cand;
                if (best == IW'(pos_reg))
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    pos_next   = best[AW-1:0];
                    state_next = H_DN_L;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        lv_reg     <= lv_next;
        has_r_reg  <= has_r_next;
        result_reg <= result_next;
        if (we && waddr == '0)
        begin
            top_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign busy   = (state_reg != H_IDLE);
    assign result = result_reg;
    assign top    = top_reg;
    assign size   = size_reg;

endmodule

>>> hdl/streaming_running_median.sv
// Running median top level: insert sequencer over two heaps and the output register.
// Each accepted sample holds in_stall until it is placed and its result is registered, so
// the next sample is not taken before the last one is through. A dropped sample only sets
// overflow, a plain push sifts up, and a push-pop sifts down and then pushes the moved
// sample on the other heap. A sample is placed by at most one push-pop and one push on the
// heaps. Every sift level, going up or down, goes through the heap memory's single read port,
// with up to log2 of CAPACITY/2 levels. in_stall is high for the whole insert. The result
// waits in an output register, and the next sample is taken while it waits. A sample arriving
// with CAPACITY samples held is dropped with overflow set.
module streaming_running_median
    import srm_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IN_W-1:0]     sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [MEDIAN_W-1:0] median_doubled,
    output logic [COUNT_W-1:0]         sample_count,
    output logic                       overflow
);

    localparam int HALF = (CAPACITY + 1) / 2;
    localparam int SW   = $clog2(HALF + 1);
    localparam int HW   = SW + 1;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_PP   = 2'd1;
    localparam logic [1:0] T_WAIT = 2'd2;
    localparam logic [1:0] T_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       pp_upper_reg, pp_upper_next;
    logic       ovf_reg, ovf_next;
    logic       out_valid_reg, out_valid_next;
    logic signed [MEDIAN_W-1:0] median_reg, median_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       overflow_reg, overflow_next;

    heap_cmd_t lo_cmd, up_cmd;
    logic signed [SAMPLE_WIDTH-1:0] lo_din, up_din, lo_res, up_res, lo_top, up_top, x;
    logic lo_busy, up_busy;
    logic [SW-1:0] lo_size, up_size;
    logic [HW-1:0] held;
    logic signed [MEDIAN_W-1:0] lo_ext, up_ext;

    srm_heap #(.DEPTH(HALF), .DW(SAMPLE_WIDTH), .IS_MAX(1'b1)) u_lower (
        .clk(clk), .rst_n(rst_n), .cmd(lo_cmd), .din(lo_din), .busy(lo_busy),
        .result(lo_res), .top(lo_top), .size(lo_size)
    );

    srm_heap #(.DEPTH(HALF), .DW(SAMPLE_WIDTH), .IS_MAX(1'b0)) u_upper (
        .clk(clk), .rst_n(rst_n), .cmd(up_cmd), .din(up_din), .busy(up_busy),
        .result(up_res), .top(up_top), .size(up_size)
    );

    assign x      = sample[SAMPLE_WIDTH-1:0];
    assign held   = HW'(lo_size) + HW'(up_size);
    assign lo_ext = MEDIAN_W'(lo_top);
    assign up_ext = MEDIAN_W'(up_top);

    always_comb
    begin
        state_next     = state_reg;
        pp_upper_next  = pp_upper_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        median_next    = median_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        lo_cmd         = '{start: 1'b0, op: OP_PUSH};
        up_cmd         = '{start: 1'b0, op: OP_PUSH};
        lo_din         = x;
        up_din         = x;
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    ovf_next = 1'b0;
                    if (held >= HW'(CAPACITY))
                    begin
                        ovf_next   = 1'b1;
                        state_next = T_FIN;
                    end
                    else if (up_size != '0 && x > up_top)
                    begin
                        up_cmd.start = 1'b1;
                        if (HW'(up_size) == HW'(lo_size) + 1'b1)
                        begin
                            up_cmd.op     = OP_PUSH_POP;
                            pp_upper_next = 1'b1;
                            state_next    = T_PP;
                        end
                        else
                        begin
                            state_next = T_WAIT;
                        end
                    end
                    else
                    begin
                        lo_cmd.start = 1'b1;
                        if (HW'(lo_size) == HW'(up_size) + 1'b1)
                        begin
                            lo_cmd.op     = OP_PUSH_POP;
                            pp_upper_next = 1'b0;
                            state_next    = T_PP;
                        end
                        else
                        begin
                            state_next = T_WAIT;
                        end
                    end
                end
            end
            T_PP:
            begin
                if (pp_upper_reg && !up_busy)
                begin
                    lo_cmd.start = 1'b1;
                    lo_din       = up_res;
                    state_next   = T_WAIT;
                end
                else if (!pp_upper_reg && !lo_busy)
                begin
                    up_cmd.start = 1'b1;
                    up_din       = lo_res;
                    state_next   = T_WAIT;
                end
            end
            T_WAIT:
            begin
                if (!lo_busy && !up_busy)
                begin
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    overflow_next  = ovf_reg;
                    count_next     = COUNT_W'(held);
                    if (lo_size > up_size)
                    begin
                        median_next = lo_ext + lo_ext;
                    end
                    else if (up_size > lo_size)
                    begin
                        median_next = up_ext + up_ext;
                    end
                    else if (lo_size == '0)
                    begin
                        median_next = '0;
                    end
                    else
                    begin
                        median_next = lo_ext + up_ext;
                    end
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_upper_reg <= pp_upper_next;
        ovf_reg      <= ovf_next;
        median_reg   <= median_next;
        count_reg    <= count_next;
        overflow_reg <= overflow_next;
    end

    assign in_stall       = (state_reg != T_IDLE);
    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;
    assign sample_count   = count_reg;
    assign overflow       = overflow_reg;

endmodule

>>> hdl/srm_checker.sv
// Port-level checks for the running median block, bound to the top level.
module srm_checker
    import srm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [MEDIAN_W-1:0] median_doubled,
    input logic [COUNT_W-1:0]         sample_count,
    input logic                       overflow
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted word did not start an insert");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != '0)
        else $error("result word with zero count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> sample_count == COUNT_W'(CAPACITY))
        else $error("overflow below capacity");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_doubled)
            && $stable(sample_count) && $stable(overflow))
        else $error("stalled result word changed");

endmodule

bind streaming_running_median srm_checker #(.CAPACITY(CAPACITY)) u_srm_checker (.*);

>>> verif/tb_streaming_running_median.sv
// Testbench for the streaming running median: two-heap predictor, scoreboard, random idling.
`timescale 1ns / 1ps
module tb_streaming_running_median;
    import srm_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int HALF = (CAP + 1) / 2;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median;
        logic [COUNT_W-1:0]         count;
        logic                       ovf;
    } median_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [IN_W-1:0] sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [COUNT_W-1:0] sample_count;
    logic overflow;

    streaming_running_median dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .median_doubled(median_doubled), .sample_count(sample_count),
        .overflow(overflow)
    );

    always #1 clk = ~clk;

    logic signed [31:0] lo_heap [HALF];
    logic signed [31:0] hi_heap [HALF];
    int lo_n, hi_n;
    logic signed [31:0] pending_samples [$];
    median_word_t expected_medians [$];
    int errors = 0;
    int words_in = 0, words_out = 0, ovf_seen = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    int hold_len = 0;
    int idle_cycles = 0;

    function automatic bit above(logic signed [31:0] a, logic signed [31:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(bit is_max, logic signed [31:0] v);
        int p, par;
        logic signed [31:0] t;
        p = is_max ? lo_n : hi_n;
        if (p >= HALF)
            return;
        if (is_max) lo_heap[p] = v; else hi_heap[p] = v;
        while (p > 0)
        begin
            par = (p - 1) / 2;
            if (is_max)
            begin
                if (!above(lo_heap[p], lo_heap[par], 1)) break;
                t = lo_heap[p]; lo_heap[p] = lo_heap[par]; lo_heap[par] = t;
            end
            else
            begin
                if (!above(hi_heap[p], hi_heap[par], 0)) break;
                t = hi_heap[p]; hi_heap[p] = hi_heap[par]; hi_heap[par] = t;
            end
            p = par;
        end
        if (is_max) lo_n++; else hi_n++;
    endtask

    task automatic heap_push_pop(bit is_max, logic signed [31:0] v,
                                 output logic signed [31:0] top);
        int p, best, l, r, n;
        logic signed [31:0] h [HALF];
        n = is_max ? lo_n : hi_n;
        if (is_max) h = lo_heap; else h = hi_heap;
        if (n == 0 || !above(h[0], v, is_max))
        begin
            top = v;
            return;
        end
        top = h[0];
        h[0] = v;
        p = 0;
        forever
        begin
            best = p; l = 2 * p + 1; r = l + 1;
            if (l < n && above(h[l], h[best], is_max)) best = l;
            if (r < n && above(h[r], h[best], is_max)) best = r;
            if (best == p) break;
            v = h[p]; h[p] = h[best]; h[best] = v;
            p = best;
        end
        if (is_max) lo_heap = h; else hi_heap = h;
    endtask

    task automatic predict_median(logic signed [31:0] x);
        median_word_t w;
        logic signed [31:0] moved;
        w.ovf = 1'b0;
        if (lo_n + hi_n >= CAP)
            w.ovf = 1'b1;
        else if (hi_n > 0 && x > hi_heap[0])
        begin
            if (hi_n == lo_n + 1)
            begin
                heap_push_pop(0, x, moved);
                heap_push(1, moved);
            end
            else
                heap_push(0, x);
        end
        else
        begin
            if (lo_n == hi_n + 1)
            begin
                heap_push_pop(1, x, moved);
                heap_push(0, moved);
            end
            else
                heap_push(1, x);
        end
        if (lo_n > hi_n) w.median = 2 * 33'(lo_heap[0]);
        else if (hi_n > lo_n) w.median = 2 * 33'(hi_heap[0]);
        else if (lo_n == 0) w.median = '0;
        else w.median = 33'(lo_heap[0]) + 33'(hi_heap[0]);
        w.count = COUNT_W'(lo_n + hi_n);
        if (w.ovf) ovf_seen++;
        expected_medians.push_back(w);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_out, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_median(sample);
            words_in++;
        end
        if (!(in_valid && in_stall))
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                sample <= pending_samples.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end

    // receiver hold-off
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_recv <= 1'b1;
            hold_len <= hold_len - 1;
        end
        else
            hold_recv <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_medians.size() == 0)
            begin
                $display("MISMATCH unexpected word %0d", words_out);
                errors++;
            end
            else
            begin
                median_word_t w;
                w = expected_medians.pop_front();
                if (median_doubled !== w.median)
                    report_mismatch("median_doubled", median_doubled, w.median);
                if (sample_count !== w.count)
                    report_mismatch("sample_count", sample_count, w.count);
                if (overflow !== w.ovf)
                    report_mismatch("overflow", overflow, w.ovf);
            end
            words_out++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
                $display("tb_streaming_running_median: done, errors");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_sample(int mode);
        case (mode)
            0: return 32'($urandom);
            1: return 32'($urandom_range(20)) - 10;
            2: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return 32'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    task automatic drain;
        while (pending_samples.size() > 0 || in_valid || expected_medians.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        lo_n = 0;
        hi_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, ties, even/odd sums at full width
        pending_samples = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                            0, -1, 1, 5, 5, 5, -7, 32'sh80000000, 32'sh7FFFFFFF,
                            32'h55555555, 32'hAAAAAAAA, 3, 2, 1, 0, -2};
        drain();

        // back pressure: receiver held off while sender keeps offering
        for (int i = 0; i < 40; i++) pending_samples.push_back(rand_sample(0));
        hold_len = 3000;
        @(posedge clk);
        while (hold_len > 0 || hold_recv)
            @(posedge clk);
        drain();

        // random phases, then fill to capacity and overflow
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 25 : 58) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 25 : 58) : 0;
            n = (ph == 3) ? CAP + 400 - (lo_n + hi_n) : 250;
            for (int i = 0; i < n; i++)
                pending_samples.push_back(rand_sample($urandom_range(3)));
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 60; i++) pending_samples.push_back(rand_sample(0));
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d samples, %0d results, %0d overflow drops", words_in,
                 words_out, ovf_seen);
        $display("idling phases, long receiver hold-off and full store included");
        if (errors == 0 && expected_medians.size() == 0)
            $display("tb_streaming_running_median: done, clean");
        else
            $display("tb_streaming_running_median: done, errors");
        $finish;
    end
endmodule
